### design/olpfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package olpfs_pkg;

  localparam int PAGE_COUNT    = 4;
  localparam int DISPLAY_WIDTH = 128;

  localparam int PAGE_W   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int COL_W    = $clog2(DISPLAY_WIDTH);
  localparam int ADDR_W   = PAGE_W + COL_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;

  localparam int SELECT_LEN = 4;
  localparam int LAST_POS   = SELECT_LEN + DISPLAY_WIDTH;
  localparam int POS_W      = $clog2(LAST_POS + 1);

  localparam int INIT_LEN = 24;
  localparam int INIT_W   = $clog2(INIT_LEN);

  localparam logic [2:0] CMD_INIT   = 3'd0;
  localparam logic [2:0] CMD_PIXEL  = 3'd1;
  localparam logic [2:0] CMD_CLEAR  = 3'd2;
  localparam logic [2:0] CMD_FLUSH  = 3'd3;
  localparam logic [2:0] CMD_TOGGLE = 3'd4;

  localparam logic [7:0] CTRL_CMD  = 8'h00;
  localparam logic [7:0] CTRL_DATA = 8'h40;
  localparam logic [7:0] PAGE_BASE = 8'hB0;
  localparam logic [7:0] COL_HIGH  = 8'h10;
  localparam logic [7:0] DISP_ON   = 8'hAF;
  localparam logic [7:0] DISP_OFF  = 8'hAE;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       transfer_start;
    logic [7:0] transfer_length;
    logic       transfer_end;
    logic       flush_idle;
    logic       last;
  } res_t;

  function automatic logic [7:0] init_byte(logic [INIT_W-1:0] idx, logic [7:0] contrast);
    logic [7:0] b;
    case (idx)
      5'd0:    b = CTRL_CMD;
      5'd1:    b = 8'hA8;
      5'd2:    b = 8'(PAGE_COUNT * 8 - 1);
      5'd3:    b = 8'hD3;
      5'd4:    b = 8'h00;
      5'd5:    b = 8'h40;
      5'd6:    b = 8'hA1;
      5'd7:    b = 8'hC8;
      5'd8:    b = 8'hDA;
      5'd9:    b = 8'h02;
      5'd10:   b = 8'h81;
      5'd11:   b = contrast;
      5'd12:   b = 8'hA4;
      5'd13:   b = 8'hA6;
      5'd14:   b = 8'hD5;
      5'd15:   b = 8'h80;
      5'd16:   b = 8'h20;
      5'd17:   b = 8'h02;
      5'd18:   b = 8'h8D;
      5'd19:   b = 8'h14;
      5'd20:   b = DISP_ON;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### design/olpfs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module olpfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### design/oled_page_framebuffer_streamer.sv
// Channel   Ports                                   Handshake
// command   cmd_i x_coord_i y_coord_i pixel_on_i    start_i, taken when busy_o is low
// result    byte_valid_o .. last_o                  strobe_o, one-cycle strobe per beat
// config    cfg_wdata_i (contrast)                  cfg_we_i, no wait
//
// Init: 24 beats. Toggle: 2 beats (S_TOG). Clear, idle pull: done in S_IDLE.
// Flush pull: select/control bytes come from S_IDLE; a data byte goes through
// S_FRD and S_FDAT (RAM read). Set pixel: read-modify-write via S_PRD and
// S_PWR; first lit pixel of an empty page sweeps the page in S_SWEEP. Empty
// pages read as zero, so reset needs no clearing pass. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module oled_page_framebuffer_streamer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire logic [2:0] cmd_i,
  input  wire logic [7:0] x_coord_i,
  input  wire logic [7:0] y_coord_i,
  input  wire logic       pixel_on_i,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  output logic            strobe_o,
  output logic            byte_valid_o,
  output logic [7:0]      out_byte_o,
  output logic            transfer_start_o,
  output logic [7:0]      transfer_length_o,
  output logic            transfer_end_o,
  output logic            flush_idle_o,
  output logic            last_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_TOG   = 3'd2;
  localparam logic [2:0] S_FRD   = 3'd3;
  localparam logic [2:0] S_FDAT  = 3'd4;
  localparam logic [2:0] S_PRD   = 3'd5;
  localparam logic [2:0] S_PWR   = 3'd6;
  localparam logic [2:0] S_SWEEP = 3'd7;

  localparam int PC  = olpfs_pkg::PAGE_COUNT;
  localparam int PW  = olpfs_pkg::PAGE_W;
  localparam int CW  = olpfs_pkg::COL_W;
  localparam int AW  = olpfs_pkg::ADDR_W;
  localparam int QW  = olpfs_pkg::POS_W;
  localparam int IW  = olpfs_pkg::INIT_W;

  logic [2:0]           state_q, state_d;
  logic [PC-1:0]        dirty_q, dirty_d;
  logic [PC-1:0]        empty_q, empty_d;
  logic                 power_q, power_d;
  logic                 active_q, active_d;
  logic [PW-1:0]        fpage_q, fpage_d;
  logic [QW-1:0]        fpos_q, fpos_d;
  logic [7:0]           contrast_q;
  logic [IW-1:0]        cnt_q, cnt_d;
  logic [AW-1:0]        addr_q, addr_d;
  logic [CW-1:0]        col_q, col_d;
  logic [7:0]           bit_q, bit_d;
  logic                 on_q, on_d;
  logic                 strobe_q, strobe_d;
  olpfs_pkg::res_t      res_q, res_d;

  logic                 ram_we;
  logic [7:0]           ram_wdata;
  logic [7:0]           ram_rdata;

  logic                 in_range;
  logic [PW-1:0]        pix_page;
  logic [CW-1:0]        pix_col;
  logic                 any_dirty;
  logic [PW-1:0]        low_dirty;
  logic [PW-1:0]        pg_use;
  logic [QW-1:0]        pos_use;
  logic [QW-1:0]        col_full;

  assign in_range = (x_coord_i < 8'(olpfs_pkg::DISPLAY_WIDTH)) &&
                    (y_coord_i < 8'(PC * 8));
  assign pix_page = y_coord_i[3 +: PW];
  assign pix_col  = x_coord_i[CW-1:0];

  always_comb begin
    any_dirty = 1'b0;
    low_dirty = '0;
    for (int p = PC - 1; p >= 0; p--) begin
      if (dirty_q[p]) begin
        any_dirty = 1'b1;
        low_dirty = PW'(p);
      end
    end
  end

  assign pg_use   = active_q ? fpage_q : low_dirty;
  assign pos_use  = active_q ? fpos_q : '0;
  assign col_full = pos_use - QW'(olpfs_pkg::SELECT_LEN + 1);

  always_comb begin
    state_d   = state_q;
    dirty_d   = dirty_q;
    empty_d   = empty_q;
    power_d   = power_q;
    active_d  = active_q;
    fpage_d   = fpage_q;
    fpos_d    = fpos_q;
    cnt_d     = cnt_q;
    addr_d    = addr_q;
    col_d     = col_q;
    bit_d     = bit_q;
    on_d      = on_q;
    strobe_d  = 1'b0;
    res_d     = '0;
    ram_we    = 1'b0;
    ram_wdata = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (cmd_i)
            olpfs_pkg::CMD_INIT: begin
              active_d = 1'b0;
              fpos_d   = '0;
              power_d  = 1'b1;
              empty_d  = '1;
              dirty_d  = '1;
              cnt_d    = '0;
              state_d  = S_INIT;
            end
            olpfs_pkg::CMD_PIXEL: begin
              bit_d = 8'(1) << y_coord_i[2:0];
              on_d  = pixel_on_i;
              col_d = pix_col;
              if (in_range) begin
                dirty_d[pix_page] = 1'b1;
                if (pixel_on_i && empty_q[pix_page]) begin
                  empty_d[pix_page] = 1'b0;
                  addr_d  = {pix_page, CW'(0)};
                  state_d = S_SWEEP;
                end else if (!empty_q[pix_page]) begin
                  addr_d  = {pix_page, pix_col};
                  state_d = S_PRD;
                end
              end
            end
            olpfs_pkg::CMD_CLEAR: begin
              dirty_d = dirty_q | ~empty_q;
              empty_d = '1;
            end
            olpfs_pkg::CMD_FLUSH: begin
              strobe_d   = 1'b1;
              res_d.last = 1'b1;
              if (!active_q && !any_dirty) begin
                res_d.flush_idle = 1'b1;
              end else begin
                if (!active_q) begin
                  dirty_d[low_dirty] = 1'b0;
                  fpage_d  = low_dirty;
                  active_d = 1'b1;
                end
                if (pos_use >= QW'(olpfs_pkg::LAST_POS)) begin
                  active_d = 1'b0;
                  fpos_d   = '0;
                end else begin
                  fpos_d = pos_use + 1'b1;
                end
                res_d.byte_valid = 1'b1;
                if (pos_use < QW'(olpfs_pkg::SELECT_LEN)) begin
                  case (pos_use[1:0])
                    2'd0:    res_d.out_byte = olpfs_pkg::CTRL_CMD;
                    2'd1:    res_d.out_byte = olpfs_pkg::PAGE_BASE + 8'(pg_use);
                    2'd2:    res_d.out_byte = 8'h00;
                    default: res_d.out_byte = olpfs_pkg::COL_HIGH;
                  endcase
                  res_d.transfer_start  = (pos_use == '0);
                  res_d.transfer_length = (pos_use == '0) ? 8'(olpfs_pkg::SELECT_LEN) : 8'h00;
                  res_d.transfer_end    = (pos_use == QW'(olpfs_pkg::SELECT_LEN - 1));
                end else if (pos_use == QW'(olpfs_pkg::SELECT_LEN)) begin
                  res_d.out_byte        = olpfs_pkg::CTRL_DATA;
                  res_d.transfer_start  = 1'b1;
                  res_d.transfer_length = 8'(olpfs_pkg::DISPLAY_WIDTH + 1);
                end else begin
                  strobe_d = 1'b0;
                  addr_d   = {pg_use, col_full[CW-1:0]};
                  state_d  = S_FRD;
                end
              end
            end
            olpfs_pkg::CMD_TOGGLE: begin
              if (active_q) begin
                dirty_d[fpage_q] = 1'b1;
                active_d = 1'b0;
                fpos_d   = '0;
              end
              power_d               = !power_q;
              strobe_d              = 1'b1;
              res_d.byte_valid      = 1'b1;
              res_d.out_byte        = olpfs_pkg::CTRL_CMD;
              res_d.transfer_start  = 1'b1;
              res_d.transfer_length = 8'd2;
              state_d               = S_TOG;
            end
            default: ;
          endcase
        end
      end
      S_INIT: begin
        strobe_d              = 1'b1;
        res_d.byte_valid      = 1'b1;
        res_d.out_byte        = olpfs_pkg::init_byte(cnt_q, contrast_q);
        res_d.transfer_start  = (cnt_q == '0);
        res_d.transfer_length = (cnt_q == '0) ? 8'(olpfs_pkg::INIT_LEN) : 8'h00;
        res_d.transfer_end    = (cnt_q == IW'(olpfs_pkg::INIT_LEN - 1));
        res_d.last            = res_d.transfer_end;
        cnt_d                 = cnt_q + 1'b1;
        if (cnt_q == IW'(olpfs_pkg::INIT_LEN - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_TOG: begin
        strobe_d           = 1'b1;
        res_d.byte_valid   = 1'b1;
        res_d.out_byte     = power_q ? olpfs_pkg::DISP_ON : olpfs_pkg::DISP_OFF;
        res_d.transfer_end = 1'b1;
        res_d.last         = 1'b1;
        state_d            = S_IDLE;
      end
      S_FRD: begin
        state_d = S_FDAT;
      end
      S_FDAT: begin
        strobe_d           = 1'b1;
        res_d.byte_valid   = 1'b1;
        res_d.out_byte     = empty_q[addr_q[AW-1:CW]] ? 8'h00 : ram_rdata;
        res_d.transfer_end = (addr_q[CW-1:0] == CW'(olpfs_pkg::DISPLAY_WIDTH - 1));
        res_d.last         = 1'b1;
        state_d            = S_IDLE;
      end
      S_PRD: begin
        state_d = S_PWR;
      end
      S_PWR: begin
        ram_we    = 1'b1;
        ram_wdata = on_q ? (ram_rdata | bit_q) : (ram_rdata & ~bit_q);
        state_d   = S_IDLE;
      end
      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_wdata = (addr_q[CW-1:0] == col_q) ? bit_q : 8'h00;
        addr_d[CW-1:0] = addr_q[CW-1:0] + 1'b1;
        if (addr_q[CW-1:0] == CW'(olpfs_pkg::DISPLAY_WIDTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      dirty_q    <= '1;
      empty_q    <= '1;
      power_q    <= 1'b0;
      active_q   <= 1'b0;
      fpage_q    <= '0;
      fpos_q     <= '0;
      contrast_q <= 8'd127;
      strobe_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      dirty_q  <= dirty_d;
      empty_q  <= empty_d;
      power_q  <= power_d;
      active_q <= active_d;
      fpage_q  <= fpage_d;
      fpos_q   <= fpos_d;
      strobe_q <= strobe_d;
      if (cfg_we_i) begin
        contrast_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    addr_q <= addr_d;
    col_q  <= col_d;
    bit_q  <= bit_d;
    on_q   <= on_d;
    res_q  <= res_d;
  end

  olpfs_ram #(
    .WIDTH (8),
    .DEPTH (olpfs_pkg::RAM_DEPTH)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  assign busy_o            = (state_q != S_IDLE);
  assign strobe_o          = strobe_q;
  assign byte_valid_o      = strobe_q & res_q.byte_valid;
  assign out_byte_o        = strobe_q ? res_q.out_byte : 8'h00;
  assign transfer_start_o  = strobe_q & res_q.transfer_start;
  assign transfer_length_o = strobe_q ? res_q.transfer_length : 8'h00;
  assign transfer_end_o    = strobe_q & res_q.transfer_end;
  assign flush_idle_o      = strobe_q & res_q.flush_idle;
  assign last_o            = strobe_q & res_q.last;

endmodule

`default_nettype wire

### design/olpfs_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module olpfs_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start_i,
  input wire logic       busy_o,
  input wire logic [2:0] cmd_i,
  input wire logic [7:0] x_coord_i,
  input wire logic [7:0] y_coord_i,
  input wire logic       pixel_on_i,
  input wire logic       cfg_we_i,
  input wire logic [7:0] cfg_wdata_i,
  input wire logic       strobe_o,
  input wire logic       byte_valid_o,
  input wire logic [7:0] out_byte_o,
  input wire logic       transfer_start_o,
  input wire logic [7:0] transfer_length_o,
  input wire logic       transfer_end_o,
  input wire logic       flush_idle_o,
  input wire logic       last_o
);

  // idle beat is empty and closes its item
  a_idle_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && flush_idle_o |-> !byte_valid_o && last_o && out_byte_o == 8'h00)
    else $error("flush idle beat malformed");

  // multi-beat items run without gaps
  a_no_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |=> strobe_o)
    else $error("gap inside a multi-beat item");

  a_toggle_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && cmd_i == olpfs_pkg::CMD_TOGGLE |=>
      strobe_o && transfer_start_o && transfer_length_o == 8'd2 && !last_o)
    else $error("toggle did not open a two-byte transfer");

  a_init_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && cmd_i == olpfs_pkg::CMD_INIT |=> busy_o)
    else $error("init accepted without going busy");

  a_start_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && transfer_start_o |-> byte_valid_o && transfer_length_o != 8'h00)
    else $error("transfer start without length");

endmodule

bind oled_page_framebuffer_streamer olpfs_checker u_olpfs_checker (.*);

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_MID   = 3'd6;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
  localparam int SETTLE_CYCLES = olpfs_pkg::DISPLAY_WIDTH + 16;
  localparam int PHASE_ITEMS   = 55;

  // Beat predictor and checker for the display byte stream.
  class byte_stream_scoreboard;
    olpfs_pkg::res_t                  pending_beats[$];
    int                               mismatch_count;
    logic [7:0]                       contrast;
    logic [7:0] frame_mem [olpfs_pkg::PAGE_COUNT * olpfs_pkg::DISPLAY_WIDTH];
    logic [7:0]                       setup_seq [olpfs_pkg::INIT_LEN];
    logic [olpfs_pkg::PAGE_COUNT-1:0] dirty;
    logic [olpfs_pkg::PAGE_COUNT-1:0] empty;
    bit                               power;
    bit                               streaming;
    int                               stream_page;
    int                               stream_pos;

    function new();
      mismatch_count = 0;
      contrast       = 8'd127;
      dirty          = '1;
      empty          = '1;
      power          = 1'b0;
      streaming      = 1'b0;
      stream_page    = 0;
      stream_pos     = 0;
      foreach (frame_mem[i]) frame_mem[i] = 8'h00;
      setup_seq = '{olpfs_pkg::CTRL_CMD, 8'hA8, 8'(olpfs_pkg::PAGE_COUNT * 8 - 1), 8'hD3,
                    8'h00, 8'h40, 8'hA1, 8'hC8, 8'hDA, 8'h02, 8'h81, 8'h00,
                    8'hA4, 8'hA6, 8'hD5, 8'h80, 8'h20, 8'h02,
                    8'h8D, 8'h14, olpfs_pkg::DISP_ON, 8'h00, 8'h00, 8'h00};
    endfunction

    function olpfs_pkg::res_t make_beat(bit v, logic [7:0] b, bit st, logic [7:0] len,
                                        bit e, bit idle, bit lst);
      olpfs_pkg::res_t r;
      r.byte_valid      = v;
      r.out_byte        = b;
      r.transfer_start  = st;
      r.transfer_length = len;
      r.transfer_end    = e;
      r.flush_idle      = idle;
      r.last            = lst;
      return r;
    endfunction

    function void clear_pages();
      for (int p = 0; p < olpfs_pkg::PAGE_COUNT; p++) begin
        if (!empty[p]) begin
          for (int c = 0; c < olpfs_pkg::DISPLAY_WIDTH; c++)
            frame_mem[p*olpfs_pkg::DISPLAY_WIDTH + c] = 8'h00;
          empty[p] = 1'b1;
          dirty[p] = 1'b1;
        end
      end
    endfunction

    function void run_init();
      logic [7:0] b;
      streaming  = 1'b0;
      stream_pos = 0;
      power      = 1'b1;
      empty      = '0;
      dirty      = '1;
      for (int i = 0; i < olpfs_pkg::INIT_LEN; i++) begin
        b = (i == 11) ? contrast : setup_seq[i];
        pending_beats.push_back(make_beat(1'b1, b, i == 0,
                                          (i == 0) ? 8'(olpfs_pkg::INIT_LEN) : 8'd0,
                                          i == olpfs_pkg::INIT_LEN - 1, 1'b0,
                                          i == olpfs_pkg::INIT_LEN - 1));
      end
      clear_pages();
    endfunction

    function void draw_pixel(logic [7:0] x, logic [7:0] y, logic on);
      int p;
      int idx;
      if (x >= olpfs_pkg::DISPLAY_WIDTH || y >= olpfs_pkg::PAGE_COUNT * 8) return;
      p   = y >> 3;
      idx = p * olpfs_pkg::DISPLAY_WIDTH + x;
      if (on) begin
        empty[p] = 1'b0;
        frame_mem[idx][y[2:0]] = 1'b1;
      end else begin
        frame_mem[idx][y[2:0]] = 1'b0;
      end
      dirty[p] = 1'b1;
    endfunction

    function void pull_byte();
      int         found;
      int         pos;
      int         col;
      logic [7:0] b;
      bit         st;
      bit         e;
      logic [7:0] len;
      if (!streaming) begin
        found = -1;
        for (int p = 0; p < olpfs_pkg::PAGE_COUNT; p++) begin
          if (dirty[p] && found < 0) found = p;
        end
        if (found < 0) begin
          pending_beats.push_back(make_beat(0, 8'h00, 0, 8'd0, 0, 1, 1));
          return;
        end
        streaming        = 1'b1;
        stream_page      = found;
        stream_pos       = 0;
        dirty[found]     = 1'b0;
      end
      pos = stream_pos;
      st  = 1'b0;
      e   = 1'b0;
      len = 8'd0;
      if (pos < olpfs_pkg::SELECT_LEN) begin
        case (pos)
          0:       b = olpfs_pkg::CTRL_CMD;
          1:       b = 8'(olpfs_pkg::PAGE_BASE + stream_page);
          2:       b = 8'h00;
          default: b = olpfs_pkg::COL_HIGH;
        endcase
        st  = (pos == 0);
        len = st ? 8'(olpfs_pkg::SELECT_LEN) : 8'd0;
        e   = (pos == olpfs_pkg::SELECT_LEN - 1);
      end else if (pos == olpfs_pkg::SELECT_LEN) begin
        b   = olpfs_pkg::CTRL_DATA;
        st  = 1'b1;
        len = 8'(olpfs_pkg::DISPLAY_WIDTH + 1);
      end else begin
        col = pos - olpfs_pkg::SELECT_LEN - 1;
        b   = frame_mem[stream_page*olpfs_pkg::DISPLAY_WIDTH + col];
        e   = (col == olpfs_pkg::DISPLAY_WIDTH - 1);
      end
      if (pos >= olpfs_pkg::LAST_POS) begin
        streaming  = 1'b0;
        stream_pos = 0;
      end else begin
        stream_pos = pos + 1;
      end
      pending_beats.push_back(make_beat(1, b, st, len, e, 0, 1));
    endfunction

    function void run_toggle();
      if (streaming) begin
        dirty[stream_page] = 1'b1;
        streaming          = 1'b0;
        stream_pos         = 0;
      end
      power = !power;
      pending_beats.push_back(make_beat(1, olpfs_pkg::CTRL_CMD, 1, 8'd2, 0, 0, 0));
      pending_beats.push_back(make_beat(1, power ? olpfs_pkg::DISP_ON : olpfs_pkg::DISP_OFF,
                                        0, 8'd0, 1, 0, 1));
    endfunction

    function void note_command(logic [2:0] cmd, logic [7:0] x, logic [7:0] y, logic on);
      case (cmd)
        olpfs_pkg::CMD_INIT:   run_init();
        olpfs_pkg::CMD_PIXEL:  draw_pixel(x, y, on);
        olpfs_pkg::CMD_CLEAR:  clear_pages();
        olpfs_pkg::CMD_FLUSH:  pull_byte();
        olpfs_pkg::CMD_TOGGLE: run_toggle();
        default:    ;
      endcase
    endfunction

    function string show(olpfs_pkg::res_t r);
      return $sformatf("v=%0d byte=%02h start=%0d len=%0d end=%0d idle=%0d last=%0d",
                       r.byte_valid, r.out_byte, r.transfer_start, r.transfer_length,
                       r.transfer_end, r.flush_idle, r.last);
    endfunction

    function void check_beat(olpfs_pkg::res_t got);
      olpfs_pkg::res_t exp;
      if (pending_beats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected beat: %s", show(got));
        return;
      end
      exp = pending_beats.pop_front();
      if (got.byte_valid !== exp.byte_valid || got.out_byte !== exp.out_byte ||
          got.transfer_start !== exp.transfer_start ||
          got.transfer_length !== exp.transfer_length ||
          got.transfer_end !== exp.transfer_end || got.flush_idle !== exp.flush_idle ||
          got.last !== exp.last) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("beat mismatch at %0t\n  exp %s\n  got %s", $time, show(exp), show(got));
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       start_i;
  logic       busy_o;
  logic [2:0] cmd_i;
  logic [7:0] x_coord_i;
  logic [7:0] y_coord_i;
  logic       pixel_on_i;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;
  logic       strobe_o;
  logic       byte_valid_o;
  logic [7:0] out_byte_o;
  logic       transfer_start_o;
  logic [7:0] transfer_length_o;
  logic       transfer_end_o;
  logic       flush_idle_o;
  logic       last_o;

  byte_stream_scoreboard sb;
  int                    items_sent;
  bit                    quiet;

  oled_page_framebuffer_streamer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .cmd_i            (cmd_i),
    .x_coord_i        (x_coord_i),
    .y_coord_i        (y_coord_i),
    .pixel_on_i       (pixel_on_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .strobe_o         (strobe_o),
    .byte_valid_o     (byte_valid_o),
    .out_byte_o       (out_byte_o),
    .transfer_start_o (transfer_start_o),
    .transfer_length_o(transfer_length_o),
    .transfer_end_o   (transfer_end_o),
    .flush_idle_o     (flush_idle_o),
    .last_o           (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk_i) begin : beat_monitor
    olpfs_pkg::res_t seen;
    if (rst_ni && strobe_o === 1'b1) begin
      seen.byte_valid      = byte_valid_o;
      seen.out_byte        = out_byte_o;
      seen.transfer_start  = transfer_start_o;
      seen.transfer_length = transfer_length_o;
      seen.transfer_end    = transfer_end_o;
      seen.flush_idle      = flush_idle_o;
      seen.last            = last_o;
      sb.check_beat(seen);
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Returns at a time step with no pending assignment to start_i.
  task automatic send_item(input logic [2:0] cmd, input logic [7:0] x,
                           input logic [7:0] y, input logic on);
    int gap;
    start_i    <= 1'b1;
    cmd_i      <= cmd;
    x_coord_i  <= x;
    y_coord_i  <= y;
    pixel_on_i <= on;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_command(cmd, x, y, on);
    if (cmd < CMD_SPARE_FIRST) items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_noise(input logic [2:0] cmd);
    send_item(cmd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic send_pixel();
    if ($urandom_range(0, 9) == 0)
      send_noise(olpfs_pkg::CMD_PIXEL);
    else
      send_item(olpfs_pkg::CMD_PIXEL, 8'($urandom_range(0, olpfs_pkg::DISPLAY_WIDTH - 1)),
                8'($urandom_range(0, olpfs_pkg::PAGE_COUNT * 8 - 1)),
                1'($urandom_range(0, 1)));
  endtask

  task automatic settle();
    start_i <= 1'b0;
    while (sb.pending_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_contrast(input logic [7:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    sb.contrast = value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // pulls until the page stream in progress, or the next one, has gone out
  task automatic finish_stream();
    do send_noise(olpfs_pkg::CMD_FLUSH); while (sb.streaming);
  endtask

  task automatic random_action();
    int r;
    int n;
    int y_base;
    r     = $urandom_range(0, 99);
    quiet = ($urandom_range(0, 4) == 0);
    if (r < 35) begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 140) : $urandom_range(1, 20);
      repeat (n) send_noise(olpfs_pkg::CMD_FLUSH);
    end else if (r < 62) begin
      send_pixel();
    end else if (r < 68) begin
      send_noise(olpfs_pkg::CMD_CLEAR);
    end else if (r < 76) begin
      send_noise(olpfs_pkg::CMD_TOGGLE);
    end else if (r < 80) begin
      send_noise(olpfs_pkg::CMD_INIT);
    end else if (r < 85) begin
      send_noise(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)));
    end else if (r < 89) begin
      finish_stream();
    end else begin
      y_base = $urandom_range(0, olpfs_pkg::PAGE_COUNT - 1) * 8;
      repeat ($urandom_range(4, 10))
        send_item(olpfs_pkg::CMD_PIXEL,
                  8'($urandom_range(0, olpfs_pkg::DISPLAY_WIDTH - 1)),
                  8'(y_base + $urandom_range(0, 7)), 1'($urandom_range(0, 3) != 0));
    end
  endtask

  initial begin
    logic [7:0] contrast_plan [4];
    int         phase_end;
    sb          = new();
    items_sent  = 0;
    quiet       = 1'b0;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    cmd_i       = olpfs_pkg::CMD_INIT;
    x_coord_i   = 8'd0;
    y_coord_i   = 8'd0;
    pixel_on_i  = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 8'd0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset contrast, aborts, range edges, spare codes
    send_item(olpfs_pkg::CMD_FLUSH, 8'd0, 8'd0, 1'b0);
    send_item(olpfs_pkg::CMD_FLUSH, 8'd0, 8'd0, 1'b0);
    send_item(olpfs_pkg::CMD_TOGGLE, 8'd0, 8'd0, 1'b0);
    send_item(olpfs_pkg::CMD_TOGGLE, 8'hFF, 8'hFF, 1'b1);
    send_item(olpfs_pkg::CMD_INIT, 8'd0, 8'd0, 1'b0);
    send_item(olpfs_pkg::CMD_FLUSH, 8'd0, 8'd0, 1'b0);
    send_item(olpfs_pkg::CMD_INIT, 8'hFF, 8'hFF, 1'b1);
    send_item(olpfs_pkg::CMD_PIXEL, 8'd0, 8'd0, 1'b1);
    send_item(olpfs_pkg::CMD_PIXEL, 8'(olpfs_pkg::DISPLAY_WIDTH - 1),
              8'(olpfs_pkg::PAGE_COUNT * 8 - 1), 1'b1);
    send_item(olpfs_pkg::CMD_PIXEL, 8'(olpfs_pkg::DISPLAY_WIDTH), 8'd5, 1'b1);
    send_item(olpfs_pkg::CMD_PIXEL, 8'd3, 8'(olpfs_pkg::PAGE_COUNT * 8), 1'b1);
    send_item(olpfs_pkg::CMD_PIXEL, 8'hFF, 8'hFF, 1'b1);
    send_item(olpfs_pkg::CMD_PIXEL, 8'(olpfs_pkg::DISPLAY_WIDTH - 1),
              8'(olpfs_pkg::PAGE_COUNT * 8 - 1), 1'b0);
    send_item(olpfs_pkg::CMD_PIXEL, 8'd10, 8'd12, 1'b0);
    send_item(CMD_SPARE_FIRST, 8'h55, 8'hAA, 1'b1);
    send_item(CMD_SPARE_MID, 8'hAA, 8'h55, 1'b0);
    send_item(CMD_SPARE_LAST, 8'hFF, 8'hFF, 1'b1);
    send_item(olpfs_pkg::CMD_CLEAR, 8'd0, 8'd0, 1'b0);
    send_item(olpfs_pkg::CMD_PIXEL, 8'd64, 8'd17, 1'b1);
    repeat (5) send_item(olpfs_pkg::CMD_FLUSH, 8'd0, 8'd0, 1'b0);
    send_item(olpfs_pkg::CMD_CLEAR, 8'd0, 8'd0, 1'b0);

    contrast_plan = '{8'hFF, 8'h00, 8'($urandom_range(1, 254)), 8'($urandom_range(0, 255))};
    for (int ph = 0; ph < 4; ph++) begin
      write_contrast(contrast_plan[ph]);
      quiet = (ph == 1);
      send_noise(olpfs_pkg::CMD_INIT);
      if (ph == 0) finish_stream();
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) random_action();
    end

    settle();
    if (sb.mismatch_count == 0 && sb.pending_beats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
